// File: src/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define BXD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BXD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bxd_pkg.sv
// Types, constants and helper functions of the box average downscaler.
`default_nettype none

package bxd_pkg;

    // Limits of the tile geometry.
    localparam int MAX_TILE_COLS = 64;
    localparam int MAX_TILE_W    = 64;
    localparam int MAX_TILE_H    = 64;

    // Field and register widths.
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_TILE_COLS);
    localparam int CNT_W     = 6;
    localparam int AREA_W    = $clog2(MAX_TILE_W * MAX_TILE_H + 1);
    localparam int SUM_W     = 20;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Pixel value limits after clamping.
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_HI  = 8'd254;
    localparam logic [PIX_W-1:0] PIX_LO  = 8'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_W  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_H  = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_OUT_COLS = 7'd16;
    localparam logic [CFG_W-1:0] RST_BLOCK_W  = 7'd1;
    localparam logic [CFG_W-1:0] RST_BLOCK_H  = 7'd1;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified pixel on its way to the accumulators.
    typedef struct packed {
        logic [COL_W-1:0]  idx;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic              emit;
        logic              row_end;
        logic [AREA_W-1:0] area;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UPD,
        S_DIV,
        S_PUSH
    } t_back_state;

    // Zero becomes one and full scale becomes one below it.
    function automatic logic [PIX_W-1:0] clamp_channel(input logic [PIX_W-1:0] v);
        logic [PIX_W-1:0] c;
        c = v;
        if (v == PIX_MAX) begin
            c = PIX_HI;
        end else if (v == '0) begin
            c = PIX_LO;
        end
        return c;
    endfunction

    // A zero register counts as one, a value above the maximum as the maximum.
    function automatic logic [CFG_W-1:0] limit_of(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] l;
        l = v;
        if (v == '0) begin
            l = CFG_W'(1);
        end else if (v > maxv) begin
            l = maxv;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

// File: src/bxd_ifs.sv
// Valid/ready channel interfaces for source pixels and tile averages.
`default_nettype none

interface bxd_pix_if
    import bxd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface bxd_tile_if
    import bxd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_avg;
    logic [PIX_W-1:0] green_avg;
    logic [PIX_W-1:0] blue_avg;
    logic             row_end;

    modport source (output valid, output red_avg, output green_avg, output blue_avg,
                    output row_end, input ready);
    modport sink (input valid, input red_avg, input green_avg, input blue_avg,
                  input row_end, output ready);
endinterface

`default_nettype wire

// File: src/box_average_downscaler.sv
// Top level of the box average downscaler: front end, queue and back end.
//
// Usage: source RGB pixels enter in raster order on i_pix, one per beat. Each
// channel is clamped to 1..254 and summed into a per-column accumulator for
// the tile it belongs to. When the last pixel of a block_w by block_h tile
// arrives, one beat leaves on o_tile with the three truncated averages and
// row_end set on the last tile of the output row. The source row must be
// out_cols * block_w pixels wide. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no pixel is
// in flight, and the block itself does not enforce it. The back end takes
// each pixel through queue pop, accumulator read and accumulator write; a
// pixel that completes a tile adds the bit-serial divider and the loading
// of the result register. A four-beat queue lets the front keep accepting
// meanwhile. Reset clears counters, queue, accumulators (through per-column
// valid bits) and the result valid flag, and restores out_cols 16,
// block_w 1, block_h 1. When the receiver stalls, the result is held in
// the output register, the back end waits with the next result, and
// i_pix.ready falls once the queue is full.
`default_nettype none
`include "assert_macros.svh"

module box_average_downscaler
    import bxd_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    bxd_pix_if.sink              i_pix,
    bxd_tile_if.source           o_tile,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data
);

    // Queue traffic between the front end and the back end.
    logic      q_push;
    logic      q_pop;
    t_task     q_in;
    t_task     q_out;
    t_q_status q_stat;

    // The front end tracks tile position and decides which pixel closes a tile.
    bxd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_task     (q_in)
    );

    bxd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_in),
        .i_pop   (q_pop),
        .o_task  (q_out),
        .o_stat  (q_stat)
    );

    // The back end accumulates and divides, one queued pixel at a time.
    bxd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_task   (q_out),
        .o_pop    (q_pop),
        .o_tile   (o_tile)
    );

    // The queue is never written when full nor read when empty.
    `BXD_ASSERT(a_q_no_overflow, i_clk, i_rst_n, q_push |-> !q_stat.full, "queue overflow")
    `BXD_ASSERT(a_q_no_underflow, i_clk, i_rst_n, q_pop |-> !q_stat.empty, "queue underflow")
    // In the cycle after one with reset asserted, nothing is queued and no result is pending.
    `BXD_ASSERT_ALWAYS(a_reset_clean, i_clk,
        !i_rst_n |=> (q_stat.empty && !o_tile.valid), "state left after reset")

endmodule

`default_nettype wire

// File: src/bxd_fifo.sv
// Short queue of classified pixels between the front and the back.
`default_nettype none

module bxd_fifo
    import bxd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  wire t_task i_task,
    input  wire        i_pop,
    output t_task      o_task,
    output t_q_status  o_stat
);

    t_task             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW-1:0]   n_wr;
    logic [Q_AW-1:0]   n_rd;
    logic [Q_AW:0]     n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + Q_AW'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    assign o_task       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// File: src/bxd_front.sv
// Front end: configuration registers, pixel acceptance, tile position tracking.
`default_nettype none

module bxd_front
    import bxd_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    bxd_pix_if.sink              i_pix,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data,
    input  wire t_q_status       i_q_stat,
    output logic                 o_push,
    output t_task                o_task
);

    logic [CFG_W-1:0]   r_out_cols;
    logic [CFG_W-1:0]   r_block_w;
    logic [CFG_W-1:0]   r_block_h;
    logic [CNT_W-1:0]   r_col_in_tile;
    logic [COL_W-1:0]   r_tile_col;
    logic [CNT_W-1:0]   r_row_in_tile;
    logic [CNT_W-1:0]   n_col_in_tile;
    logic [COL_W-1:0]   n_tile_col;
    logic [CNT_W-1:0]   n_row_in_tile;

    logic [CFG_W-1:0]   lim_oc;
    logic [CFG_W-1:0]   lim_bw;
    logic [CFG_W-1:0]   lim_bh;
    logic [2*CFG_W-1:0] area_full;
    logic               last_col;
    logic               last_row;
    logic               last_tile;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cols <= RST_OUT_COLS;
            r_block_w  <= RST_BLOCK_W;
            r_block_h  <= RST_BLOCK_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUT_COLS: r_out_cols <= i_cfg_data;
                CFG_BLOCK_W:  r_block_w  <= i_cfg_data;
                CFG_BLOCK_H:  r_block_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_oc    = limit_of(r_out_cols, CFG_W'(MAX_TILE_COLS));
    assign lim_bw    = limit_of(r_block_w, CFG_W'(MAX_TILE_W));
    assign lim_bh    = limit_of(r_block_h, CFG_W'(MAX_TILE_H));
    assign area_full = lim_bw * lim_bh;

    // A counter at or beyond its limit counts as being at its last position.
    assign last_col  = ({1'b0, r_col_in_tile} + CFG_W'(1)) >= lim_bw;
    assign last_row  = ({1'b0, r_row_in_tile} + CFG_W'(1)) >= lim_bh;
    assign last_tile = ({1'b0, r_tile_col} + CFG_W'(1)) >= lim_oc;

    assign i_pix.ready = !i_q_stat.full;
    assign o_push      = i_pix.valid && i_pix.ready;

    assign o_task.idx     = r_tile_col;
    assign o_task.red     = clamp_channel(i_pix.red_in);
    assign o_task.green   = clamp_channel(i_pix.green_in);
    assign o_task.blue    = clamp_channel(i_pix.blue_in);
    assign o_task.emit    = last_col && last_row;
    assign o_task.row_end = last_tile;
    assign o_task.area    = AREA_W'(area_full);

    always_comb begin
        n_col_in_tile = r_col_in_tile + CNT_W'(1);
        n_tile_col    = r_tile_col;
        n_row_in_tile = r_row_in_tile;
        if (last_col) begin
            n_col_in_tile = '0;
            if (last_tile) begin
                n_tile_col    = '0;
                n_row_in_tile = last_row ? '0 : r_row_in_tile + CNT_W'(1);
            end else begin
                n_tile_col = r_tile_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_in_tile <= '0;
            r_tile_col    <= '0;
            r_row_in_tile <= '0;
        end else if (o_push) begin
            r_col_in_tile <= n_col_in_tile;
            r_tile_col    <= n_tile_col;
            r_row_in_tile <= n_row_in_tile;
        end
    end

endmodule

`default_nettype wire

// File: src/bxd_back.sv
// Back end: column accumulators, iterative averaging divider, result register.
`default_nettype none

module bxd_back
    import bxd_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_q_status i_q_stat,
    input  wire t_task     i_task,
    output logic           o_pop,
    bxd_tile_if.source     o_tile
);

    t_back_state          r_state;
    t_back_state          n_state;
    t_task                r_item;

    // Accumulators: red in the low third, green in the middle, blue on top.
    logic [3*SUM_W-1:0]   r_acc [MAX_TILE_COLS];
    logic [MAX_TILE_COLS-1:0] r_vld;
    logic [3*SUM_W-1:0]   r_rd_data;
    logic                 r_rd_vld;

    logic [SUM_W-1:0]     r_quo [3];
    logic [AREA_W-1:0]    r_rem [3];
    logic [DIV_CNT_W-1:0] r_step;

    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_avg [3];
    logic                 r_out_row_end;

    logic                 rd_en;
    logic                 upd;
    logic                 div_run;
    logic                 out_load;
    logic                 out_free;
    logic [3*SUM_W-1:0]   base;
    logic [SUM_W-1:0]     new_sum [3];
    logic [PIX_W-1:0]     chan [3];
    logic [AREA_W:0]      trial [3];
    logic [SUM_W-1:0]     n_quo [3];
    logic [AREA_W-1:0]    n_rem [3];
    logic [PIX_W-1:0]     avg [3];

    assign out_free = !r_out_valid || o_tile.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_stat.empty) n_state = S_RD;
            S_RD:   n_state = S_UPD;
            S_UPD:  n_state = r_item.emit ? S_DIV : S_IDLE;
            S_DIV:  if (r_step == DIV_CNT_W'(SUM_W - 1)) n_state = S_PUSH;
            S_PUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        upd      = 1'b0;
        div_run  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: o_pop    = !i_q_stat.empty;
            S_RD:   rd_en    = 1'b1;
            S_UPD:  upd      = 1'b1;
            S_DIV:  div_run  = 1'b1;
            S_PUSH: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_task;
        end
    end

    // An entry without its valid bit has not been written since reset or
    // since its tile completed, and reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (upd) begin
            r_vld[r_item.idx] <= !r_item.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_acc[r_item.idx];
            r_rd_vld  <= r_vld[r_item.idx];
        end
        if (upd && !r_item.emit) begin
            r_acc[r_item.idx] <= {new_sum[2], new_sum[1], new_sum[0]};
        end
    end

    assign base    = r_rd_vld ? r_rd_data : '0;
    assign chan[0] = r_item.red;
    assign chan[1] = r_item.green;
    assign chan[2] = r_item.blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            new_sum[c] = base[c*SUM_W +: SUM_W] + SUM_W'(chan[c]);
        end
    end

    // Restoring division, one quotient bit per channel and cycle.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {r_rem[c], r_quo[c][SUM_W-1]};
            if (trial[c] >= {1'b0, r_item.area}) begin
                n_rem[c] = AREA_W'(trial[c] - {1'b0, r_item.area});
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = trial[c][AREA_W-1:0];
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b0};
            end
            avg[c] = (|r_quo[c][SUM_W-1:PIX_W]) ? PIX_MAX : r_quo[c][PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_step <= '0;
            for (int c = 0; c < 3; c++) begin
                r_quo[c] <= new_sum[c];
                r_rem[c] <= '0;
            end
        end else if (div_run) begin
            r_step <= r_step + DIV_CNT_W'(1);
            for (int c = 0; c < 3; c++) begin
                r_quo[c] <= n_quo[c];
                r_rem[c] <= n_rem[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_tile.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row_end <= r_item.row_end;
            for (int c = 0; c < 3; c++) begin
                r_out_avg[c] <= avg[c];
            end
        end
    end

    assign o_tile.valid     = r_out_valid;
    assign o_tile.red_avg   = r_out_avg[0];
    assign o_tile.green_avg = r_out_avg[1];
    assign o_tile.blue_avg  = r_out_avg[2];
    assign o_tile.row_end   = r_out_row_end;

endmodule

`default_nettype wire
